// ===== hw/rtl/histogram_equalizer_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the histogram equalizer
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef HISTOGRAM_EQUALIZER_UNIT_ASSERT_SVH
`define HISTOGRAM_EQUALIZER_UNIT_ASSERT_SVH

// Same-cycle implication
`define HEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication
`define HEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== hw/rtl/heq_pkg.sv =====
// ---------------------------------------------------------------------------
// Histogram equalizer package
// Word types, register indexes and the controller/datapath command bundle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package heq_pkg;

  localparam int GRAY_LEVELS = 256;
  localparam int PIX_W       = 8;
  localparam int STEP_W      = 3;   // divide step counter, one quotient bit per step
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_IDX_W-1:0]  REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_IMAGE_HEIGHT = 4'd1;
  localparam logic [CFG_DATA_W-1:0] DIM_RESET        = 9'd256;

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  localparam logic [PIX_W-1:0]  PIX_MAX   = 8'hFF;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel_value;
  } heq_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] mapped_pixel;
    logic             frame_last;
    logic             order_error;
  } heq_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } heq_cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic clr_wr;     // write zero to bin[idx], advance idx
    logic in_rd_bin;  // read bin at input pixel, latch pixel
    logic in_rd_map;  // read remap table at input pixel
    logic cnt_wr;     // write back bin + 1, advance pixel count
    logic map_step;   // advance pixel count for a mapped pixel
    logic out_load;   // load output register
    logic out_err;    // loaded word is an order error
    logic b_start;    // start table build: idx, sum, divisor
    logic b_rd;       // read bin[idx]
    logic b_acc;      // add read bin into running sum
    logic b_init;     // set up divide (or write saturated entry)
    logic b_div;      // one restoring divide step
  } heq_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic seen_done;  // next pixel completes the frame
    logic idx_last;   // index at last gray level
    logic sat;        // entry saturates to full scale
    logic div_last;   // final divide step
    logic out_free;   // output register can take a word
  } heq_sts_t;

endpackage

// ===== hw/rtl/heq_stream_if.sv =====
// ---------------------------------------------------------------------------
// Valid/ready stream interface
// One word moves on a clock edge with valid and ready both high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface heq_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== hw/rtl/heq_dp.sv =====
// ---------------------------------------------------------------------------
// Histogram equalizer datapath
// Bin and remap memories, pixel counter, config registers, serial divider
// for the table build, and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module heq_dp import heq_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  heq_cmd_t         cmd_i,
  output heq_sts_t         sts_o,
  input  logic [PIX_W-1:0] in_pixel_i,
  input  logic             cfg_valid_i,
  input  heq_cfg_t         cfg_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output heq_out_t         out_data_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);  // bin / count width
  localparam int DW = CW + PIX_W;                          // scaled sum width

  // Config registers
  logic [CFG_DATA_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_i.reg_index == REG_IMAGE_WIDTH) width_q <= cfg_i.wdata;
      if (cfg_i.reg_index == REG_IMAGE_HEIGHT) height_q <= cfg_i.wdata;
    end
  end

  // Clamp dimensions: zero acts as one, above max acts as max
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [WW+HW-1:0] prod;
  logic [CW-1:0]    n_q;

  always_comb begin
    if (width_q == '0)                       w_eff = WW'(1);
    else if (32'(width_q) > 32'(MAX_WIDTH))  w_eff = WW'(MAX_WIDTH);
    else                                     w_eff = WW'(width_q);
    if (height_q == '0)                      h_eff = HW'(1);
    else if (32'(height_q) > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else                                     h_eff = HW'(height_q);
  end

  assign prod = (WW+HW)'(w_eff) * (WW+HW)'(h_eff);

  // Frame size, registered after the multiply
  always_ff @(posedge clk_i) begin
    n_q <= CW'(prod);
  end

  // Control counters
  logic [PIX_W-1:0]  idx_q, idx_d;
  logic [CW-1:0]     seen_q, seen_d, seen_inc;
  logic [STEP_W-1:0] step_q, step_d;
  logic              seen_done;
  logic              div_last;
  logic              ge;
  logic              tbl_wr;

  assign seen_inc  = seen_q + CW'(1);
  assign seen_done = seen_inc >= n_q;
  assign div_last  = step_q == '0;
  assign tbl_wr    = (cmd_i.b_init & sts_o.sat) | (cmd_i.b_div & div_last);

  always_comb begin
    idx_d  = idx_q;
    seen_d = seen_q;
    step_d = step_q;
    if (cmd_i.b_start) idx_d = '0;
    else if (cmd_i.clr_wr || tbl_wr) idx_d = idx_q + PIX_W'(1);
    if (cmd_i.cnt_wr || cmd_i.map_step) seen_d = seen_done ? '0 : seen_inc;
    if (cmd_i.b_init) step_d = STEP_LAST;
    else if (cmd_i.b_div) step_d = step_q - STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      seen_q <= '0;
      step_q <= '0;
    end else begin
      idx_q  <= idx_d;
      seen_q <= seen_d;
      step_q <= step_d;
    end
  end

  // Bin memory: one read port, one write port
  logic [CW-1:0]    bin_mem [GRAY_LEVELS];
  logic [CW-1:0]    bin_rdata_q;
  logic [PIX_W-1:0] pix_q;
  logic             bin_rd, bin_we;
  logic [PIX_W-1:0] bin_raddr, bin_waddr;
  logic [CW-1:0]    bin_wdata;

  assign bin_rd    = cmd_i.in_rd_bin | cmd_i.b_rd;
  assign bin_raddr = cmd_i.in_rd_bin ? in_pixel_i : idx_q;
  assign bin_we    = cmd_i.clr_wr | cmd_i.cnt_wr;
  assign bin_waddr = cmd_i.clr_wr ? idx_q : pix_q;
  assign bin_wdata = cmd_i.clr_wr ? '0 : bin_rdata_q + CW'(1);

  always_ff @(posedge clk_i) begin
    if (bin_rd) bin_rdata_q <= bin_mem[bin_raddr];
    if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
    if (cmd_i.in_rd_bin) pix_q <= in_pixel_i;
  end

  // Table build: running sum, sum*255 / N by restoring division
  logic [CW-1:0]    cum_q, div_q;
  logic [DW-1:0]    rem_q, dsh_q, dividend;
  logic [PIX_W-1:0] quo_q, quo_next;

  assign dividend = {cum_q, PIX_W'(0)} - DW'(cum_q);
  assign ge       = rem_q >= dsh_q;
  assign quo_next = {quo_q[PIX_W-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (cmd_i.b_start) begin
      cum_q <= '0;
      div_q <= n_q;
    end else if (cmd_i.b_acc) begin
      cum_q <= cum_q + bin_rdata_q;
    end
    if (cmd_i.b_init) begin
      rem_q <= dividend;
      dsh_q <= {1'b0, div_q, (PIX_W-1)'(0)};
      quo_q <= '0;
    end else if (cmd_i.b_div) begin
      if (ge) rem_q <= rem_q - dsh_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= quo_next;
    end
  end

  // Remap table
  logic [PIX_W-1:0] map_mem [GRAY_LEVELS];
  logic [PIX_W-1:0] map_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_rd_map) map_rdata_q <= map_mem[in_pixel_i];
    if (tbl_wr) map_mem[idx_q] <= cmd_i.b_init ? PIX_MAX : quo_next;
  end

  // Output register
  logic     out_valid_q;
  heq_out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.mapped_pixel <= cmd_i.out_err ? '0 : map_rdata_q;
      out_data_q.frame_last   <= !cmd_i.out_err && seen_done;
      out_data_q.order_error  <= cmd_i.out_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Status
  assign sts_o.seen_done = seen_done;
  assign sts_o.idx_last  = idx_q == PIX_MAX;
  assign sts_o.sat       = dividend >= {div_q, PIX_W'(0)};
  assign sts_o.div_last  = div_last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== hw/rtl/heq_ctrl.sv =====
// ---------------------------------------------------------------------------
// Histogram equalizer controller
// Sequences clearing, counting, table build and mapping; issues datapath
// commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "histogram_equalizer_unit_assert.svh"

module heq_ctrl import heq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_op_i,
  output logic     in_ready_o,
  output heq_cmd_t cmd_o,
  input  heq_sts_t sts_i
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CNT   = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;
  localparam logic [2:0] S_BRD   = 3'd4;
  localparam logic [2:0] S_BACC  = 3'd5;
  localparam logic [2:0] S_BINIT = 3'd6;
  localparam logic [2:0] S_BDIV  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       mapping_q, mapping_d;
  logic       err_q, err_d;

  assign in_ready_o = state_q == S_IDLE;

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    mapping_d = mapping_q;
    err_d     = err_q;
    cmd_o     = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.idx_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          priority if (!mapping_q && in_op_i == OP_COUNT) begin
            cmd_o.in_rd_bin = 1'b1;
            state_d         = S_CNT;
          end else if (!mapping_q) begin
            err_d   = 1'b1;
            state_d = S_OUT;
          end else if (in_op_i == OP_MAP) begin
            cmd_o.in_rd_map = 1'b1;
            err_d           = 1'b0;
            state_d         = S_OUT;
          end else begin
            // count word during mapping: dropped
            state_d = S_IDLE;
          end
        end
      end
      S_CNT: begin
        cmd_o.cnt_wr = 1'b1;
        if (sts_i.seen_done) begin
          cmd_o.b_start = 1'b1;
          state_d       = S_BRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_BRD: begin
        cmd_o.b_rd = 1'b1;
        state_d    = S_BACC;
      end
      S_BACC: begin
        cmd_o.b_acc = 1'b1;
        state_d     = S_BINIT;
      end
      S_BINIT: begin
        cmd_o.b_init = 1'b1;
        if (!sts_i.sat) begin
          state_d = S_BDIV;
        end else if (sts_i.idx_last) begin
          mapping_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_BRD;
        end
      end
      S_BDIV: begin
        cmd_o.b_div = 1'b1;
        if (sts_i.div_last) begin
          if (sts_i.idx_last) begin
            mapping_d = 1'b1;
            state_d   = S_IDLE;
          end else begin
            state_d = S_BRD;
          end
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_err  = err_q;
          if (!err_q) begin
            cmd_o.map_step = 1'b1;
            if (sts_i.seen_done) begin
              mapping_d = 1'b0;
              state_d   = S_CLEAR;
            end else begin
              state_d = S_IDLE;
            end
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers; reset starts with a clearing pass over the bins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      mapping_q <= 1'b0;
      err_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      mapping_q <= mapping_d;
      err_q     <= err_d;
    end
  end

  // Checks
  `HEQ_ASSERT_NEXT(a_map_to_out, clk_i, rst_ni, in_valid_i && in_ready_o && mapping_q && (in_op_i == OP_MAP), state_q == S_OUT)
  `HEQ_ASSERT_NOW(a_clear_counting, clk_i, rst_ni, state_q == S_CLEAR, !mapping_q)
  `HEQ_ASSERT_NOW(a_map_from_build, clk_i, rst_ni, $rose(mapping_q), ($past(state_q) == S_BINIT) || ($past(state_q) == S_BDIV))

endmodule

// ===== hw/rtl/histogram_equalizer_unit.sv =====
// ---------------------------------------------------------------------------
// Histogram equalizer
// Two-pass global histogram equalization of an 8-bit grayscale frame.
// ---------------------------------------------------------------------------
// Count words build a 256-bin histogram; after width*height of them the
// block builds a remap table, entry v = floor(cum(v)*255/N), then map words
// return remapped pixels with the frame's last one flagged. A count word
// takes a bin read, then a write-back of the incremented bin; a map or
// error word waits for a free output register; a count word during mapping
// is dropped. After the last count word the table build runs one gray level
// at a time through a restoring divider: bin read, accumulate, setup, then
// 8 divide steps, or only the first three for a saturated level. After
// reset and after the last mapped pixel a clearing pass writes the 256
// bins; no pixel words are accepted during the build or clear. Config
// writes are accepted in every cycle.
`timescale 1ns / 1ps

module histogram_equalizer_unit import heq_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  heq_stream_if.sink   in_i,
  heq_stream_if.source out_o,
  heq_stream_if.sink   cfg_i
);

  heq_cmd_t cmd;
  heq_sts_t sts;
  heq_in_t  in_word;
  heq_cfg_t cfg_word;
  heq_out_t out_word;

  assign in_word     = in_i.data;
  assign cfg_word    = cfg_i.data;
  assign cfg_i.ready = 1'b1;
  assign out_o.data  = out_word;

  heq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_word.operation),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  heq_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_pixel_i  (in_word.pixel_value),
    .cfg_valid_i (cfg_i.valid),
    .cfg_i       (cfg_word),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_word)
  );

endmodule
